// ===== rtl/lcdseq_pkg.sv =====
package lcdseq_pkg;

  // Input operation codes; 5..7 are treated as no-ops
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_INIT  = 3'd1,
    OP_CLEAR = 3'd2,
    OP_CURSOR = 3'd3,
    OP_WRITE = 3'd4
  } op_e;

  localparam int unsigned PulseW = 10;
  localparam int unsigned WaitW  = 16;
  localparam int unsigned StepW  = 4;

  localparam logic [PulseW-1:0] PULSE_RESET = 10'd50;

  localparam logic [StepW-1:0] STEP_IDLE  = 4'd0;
  localparam logic [StepW-1:0] STEP_FIRST = 4'd1;
  localparam logic [StepW-1:0] INIT_STEPS = 4'd9;
  localparam logic [StepW-1:0] STEP_CMD   = 4'd10;

  localparam logic [WaitW-1:0] BOOT_WAIT  = 16'd50000;
  localparam logic [WaitW-1:0] CLEAR_WAIT = 16'd3000;

  localparam logic [7:0] BYTE_CLEAR = 8'h01;
  localparam logic [7:0] ROW0_BASE  = 8'h80;
  localparam logic [7:0] ROW1_BASE  = 8'hC0;

  typedef struct packed {
    logic [7:0]       value;
    logic             nib_only;
    logic [WaitW-1:0] wait_us;
  } init_ent_t;

  // One result transaction: pin levels after the item plus status
  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nib;
    logic       busy;
    logic       rej;
  } res_t;

  // Power-up table: four bare nibbles, then five full bytes
  function automatic init_ent_t init_entry(input logic [StepW-1:0] k);
    init_ent_t e;
    case (k)
      4'd1:    e = '{8'h03, 1'b1, 16'd5000};
      4'd2:    e = '{8'h03, 1'b1, 16'd1000};
      4'd3:    e = '{8'h03, 1'b1, 16'd1000};
      4'd4:    e = '{8'h02, 1'b1, 16'd1000};
      4'd5:    e = '{8'h28, 1'b0, 16'd1000};
      4'd6:    e = '{8'h08, 1'b0, 16'd1000};
      4'd7:    e = '{8'h01, 1'b0, 16'd2000};
      4'd8:    e = '{8'h06, 1'b0, 16'd1000};
      4'd9:    e = '{8'h0C, 1'b0, 16'd1000};
      default: e = '{8'h00, 1'b0, 16'd0};
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/lcdseq_core.sv =====
module lcdseq_core import lcdseq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PulseW-1:0] cfg_wdata_i,
  input  logic              accept_i,
  input  logic [2:0]        op_i,
  input  logic [1:0]        row_i,
  input  logic [6:0]        column_i,
  input  logic [7:0]        char_code_i,
  output res_t              res_o
);

  typedef enum logic [2:0] {
    PH_POST  = 3'd0,
    PH_HI_EN = 3'd1,
    PH_HI_LO = 3'd2,
    PH_LO_EN = 3'd3,
    PH_LO_LO = 3'd4,
    PH_BOOT  = 3'd5
  } phase_e;

  logic [PulseW-1:0] pulse_q;
  logic [StepW-1:0]  step_q, step_d;
  logic [WaitW-1:0]  wc_q, wc_d;
  logic [7:0]        byte_q, byte_d;
  phase_e            phase_q, phase_d;
  logic [WaitW-1:0]  post_q, post_d;
  logic              rs_q, rs_d;
  logic              en_q, en_d;
  logic [3:0]        nib_q, nib_d;
  logic              rej;

  logic [WaitW-1:0]  pulse_len;
  logic [WaitW-1:0]  wc_dec;
  logic              do_next;
  logic              start;
  logic [7:0]        start_val;
  logic              start_nib;
  logic [WaitW-1:0]  start_wait;
  init_ent_t         ent;
  logic [StepW-1:0]  load_k;

  assign pulse_len = (pulse_q == '0) ? WaitW'(1) : WaitW'(pulse_q);
  assign wc_dec    = (wc_q == '0) ? '0 : wc_q - WaitW'(1);

  always_comb begin
    step_d     = step_q;
    wc_d       = wc_q;
    byte_d     = byte_q;
    phase_d    = phase_q;
    post_d     = post_q;
    rs_d       = rs_q;
    en_d       = en_q;
    nib_d      = nib_q;
    rej        = 1'b0;
    do_next    = 1'b0;
    start      = 1'b0;
    start_val  = '0;
    start_nib  = 1'b0;
    start_wait = '0;
    load_k     = STEP_FIRST;

    case (op_i)
      OP_TICK: begin
        if (step_q != STEP_IDLE) begin
          wc_d = wc_dec;
          if (wc_dec == '0) begin
            unique case (phase_q)
              PH_HI_EN: begin
                en_d = 1'b0; nib_d = byte_q[7:4]; phase_d = PH_HI_LO; wc_d = pulse_len;
              end
              PH_HI_LO: begin
                en_d = 1'b1; nib_d = byte_q[3:0]; phase_d = PH_LO_EN; wc_d = pulse_len;
              end
              PH_LO_EN: begin
                en_d = 1'b0; nib_d = byte_q[3:0]; phase_d = PH_LO_LO; wc_d = pulse_len;
              end
              PH_LO_LO: begin
                phase_d = PH_POST;
                wc_d    = post_q;
                do_next = (post_q == '0);  // zero post-wait ends in this tick
              end
              PH_BOOT: begin
                start  = 1'b1;
                load_k = STEP_FIRST;
              end
              PH_POST: do_next = 1'b1;
              default: ;
            endcase
          end
        end
      end
      OP_INIT, OP_CLEAR, OP_CURSOR, OP_WRITE: begin
        if (step_q != STEP_IDLE) begin
          rej = 1'b1;
        end else begin
          rs_d = (op_i == OP_WRITE);
          if (op_i == OP_INIT) begin
            step_d  = STEP_FIRST;
            phase_d = PH_BOOT;
            wc_d    = BOOT_WAIT;
            post_d  = '0;
          end else begin
            step_d = STEP_CMD;
            start  = 1'b1;
            load_k = STEP_IDLE;
            if (op_i == OP_CLEAR) begin
              start_val  = BYTE_CLEAR;
              start_wait = CLEAR_WAIT;
            end else if (op_i == OP_CURSOR) begin
              case (row_i)
                2'd0:    start_val = ROW0_BASE | {1'b0, column_i};
                2'd1:    start_val = ROW1_BASE | {1'b0, column_i};
                default: start_val = {1'b0, column_i};
              endcase
            end else begin
              start_val = char_code_i;
            end
          end
        end
      end
      default: ;
    endcase

    // end of a byte: next table entry or back to idle
    if (do_next) begin
      if (step_q >= STEP_FIRST && step_q < INIT_STEPS) begin
        start  = 1'b1;
        load_k = step_q + StepW'(1);
      end else begin
        step_d  = STEP_IDLE;
        phase_d = PH_POST;
      end
    end

    ent = init_entry(load_k);
    if (start) begin
      if (load_k != STEP_IDLE) begin
        step_d     = load_k;
        start_val  = ent.value;
        start_nib  = ent.nib_only;
        start_wait = ent.wait_us;
      end
      byte_d = start_val;
      post_d = start_wait;
      en_d   = 1'b1;
      wc_d   = pulse_len;
      if (start_nib) begin
        phase_d = PH_LO_EN;
        nib_d   = start_val[3:0];
      end else begin
        phase_d = PH_HI_EN;
        nib_d   = start_val[7:4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q <= PULSE_RESET;
      step_q  <= STEP_IDLE;
      wc_q    <= '0;
      byte_q  <= '0;
      phase_q <= PH_POST;
      post_q  <= '0;
      rs_q    <= 1'b0;
      en_q    <= 1'b0;
      nib_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        pulse_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        step_q  <= step_d;
        wc_q    <= wc_d;
        byte_q  <= byte_d;
        phase_q <= phase_d;
        post_q  <= post_d;
        rs_q    <= rs_d;
        en_q    <= en_d;
        nib_q   <= nib_d;
      end
    end
  end

  assign res_o = '{rs: rs_d, en: en_d, nib: nib_d, busy: (step_d != STEP_IDLE), rej: rej};

endmodule

// ===== rtl/lcdseq_skid.sv =====
module lcdseq_skid import lcdseq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  res_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic out_v_q;
  logic skid_v_q;
  res_t out_q;
  res_t skid_q;
  logic acc;

  assign in_ready_o = !skid_v_q;
  assign acc        = in_valid_i && !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || out_ready_i) begin
        if (skid_v_q) begin
          out_v_q  <= 1'b1;
          skid_v_q <= 1'b0;
        end else begin
          out_v_q <= acc;
        end
      end else if (acc) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (acc) begin
        out_q <= in_data_i;
      end
    end else if (acc) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/char_lcd_nibble_interface_sequencer.sv =====
// Channel  | Dir | Handshake              | Payload
// s_axis   | in  | tvalid/tready          | tuser: operation; tdata: row, column, char_code
// m_axis   | out | tvalid/tready          | tuser: rs_level; tdata: enable, nibble, busy, rejected
// cfg      | in  | we (no back-pressure)  | wdata: enable_pulse_us
//
// One input transaction per clock while s_axis_tready_o is high; each yields exactly one result transaction.
// The sequencer state and the result are updated together; the result sits in
// an output register backed by a one-entry skid register.
// s_axis_tready_o drops only while the skid register holds a stalled result.
// Reset (rst_ni low, asynchronous) returns to idle, pins low, pulse width 50 ticks.
module char_lcd_nibble_interface_sequencer import lcdseq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [PulseW-1:0] cfg_wdata_i,     // enable_pulse_us
  // command / tick stream
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [2:0]        s_axis_tuser_i,  // [2:0] operation
  input  logic [23:0]       s_axis_tdata_i,  // [1:0] row, [8:2] column, [16:9] char_code
  // pin level stream
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic              m_axis_tuser_o,  // [0] rs_level
  output logic [7:0]        m_axis_tdata_o   // [0] enable_level, [4:1] data_nibble,
                                             // [5] busy_res, [6] rejected
);

  logic accept;
  res_t res;
  res_t res_out;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // sequencer: counters, table walk and pin registers
  lcdseq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .op_i        (s_axis_tuser_i),
    .row_i       (s_axis_tdata_i[1:0]),
    .column_i    (s_axis_tdata_i[8:2]),
    .char_code_i (s_axis_tdata_i[16:9]),
    .res_o       (res)
  );

  // result register with skid, decouples output stalls from input
  lcdseq_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (res_out)
  );

  assign m_axis_tuser_o = res_out.rs;
  assign m_axis_tdata_o = {1'b0, res_out.rej, res_out.busy, res_out.nib, res_out.en};

endmodule

// ===== rtl/lcdseq_checker.sv =====
module lcdseq_checker import lcdseq_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic              m_axis_tuser_o,
  input logic [7:0]        m_axis_tdata_o
);

  // nothing pending in reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // with the output empty the skid stage is empty too
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // a rejected command only happens mid-sequence
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[6] |-> m_axis_tdata_o[5])
    else $error("reject while idle");

  // enable is never left high once the sequencer is idle
  a_idle_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[5] |-> !m_axis_tdata_o[0])
    else $error("enable high while idle");

endmodule

bind char_lcd_nibble_interface_sequencer lcdseq_checker u_lcdseq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
